### sv/erp_pkg.sv
// ----------------------------------------------------------------------------
// erp_pkg
// Shared types, codes and constant helpers for the exponential pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package erp_pkg;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_UNF = 2'd2,
		ST_NAN = 2'd3
	} erp_status_t;

	// per-item control that rides along the whole pipe
	typedef struct packed {
		logic        neg;
		erp_status_t spec;
		logic        last;
		logic [7:0]  k;
	} erp_tag_t;

	localparam logic [63:0] LN2_Q64   = 64'hB17217F7D1CF79AC;
	localparam logic [63:0] C1_Q40    = 64'd1099366932046;
	localparam logic [63:0] C2_Q40    = 64'd547878507735;
	localparam logic [63:0] C3_Q40    = 64'd175408608416;
	localparam logic [63:0] C4_Q40    = 64'd32286169389;
	localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
	localparam logic [31:0] PINF_BITS = 32'h7F800000;

	// Q.40 coefficient rounded half up to f fraction bits
	function automatic logic [63:0] q40_to_f(input logic [63:0] c, input int f);
		return (((c << 1) >> (40 - f)) + 64'd1) >> 1;
	endfunction

	// ln2 rounded to nearest at f fraction bits
	function automatic logic [63:0] ln2_f(input int f);
		return ((LN2_Q64 >> (63 - f)) + 64'd1) >> 1;
	endfunction

endpackage

`default_nettype wire

### sv/erp_kdiv.sv
// ----------------------------------------------------------------------------
// erp_kdiv
// Range reduction: k = floor(ax / ln2), r = ax - k*ln2, two quotient bits
// per stage over four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module erp_kdiv #(
	parameter int F = 28
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire erp_pkg::erp_tag_t tag_in,
	input  wire logic [F+6:0]      ax_in,
	output logic                   v_out,
	output erp_pkg::erp_tag_t      tag_out,
	output logic [F-1:0]           r_out
);
	import erp_pkg::*;

	localparam int AXW = F + 7;
	localparam logic [AXW-1:0] LN2F = AXW'(ln2_f(F));

	logic           v_s   [0:4];
	erp_tag_t       tag_s [0:4];
	logic [AXW-1:0] rem_s [0:4];

	assign v_s[0]   = v_in;
	assign tag_s[0] = tag_in;
	assign rem_s[0] = ax_in;

	for (genvar g = 0; g < 4; g++) begin : g_stage
		localparam logic [AXW-1:0] DHI = LN2F << (7 - 2 * g);
		localparam logic [AXW-1:0] DLO = LN2F << (6 - 2 * g);
		logic [AXW-1:0] r_mid, r_nxt;
		logic           b_hi, b_lo;
		erp_tag_t       t_nxt;

		always_comb begin
			b_hi  = rem_s[g] >= DHI;
			r_mid = b_hi ? rem_s[g] - DHI : rem_s[g];
			b_lo  = r_mid >= DLO;
			r_nxt = b_lo ? r_mid - DLO : r_mid;
			t_nxt = tag_s[g];
			t_nxt.k[7 - 2 * g] = b_hi;
			t_nxt.k[6 - 2 * g] = b_lo;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[g+1] <= t_nxt;
				rem_s[g+1] <= r_nxt;
			end
		end
	end

	assign v_out   = v_s[4];
	assign tag_out = tag_s[4];
	assign r_out   = rem_s[4][F-1:0];

endmodule

`default_nettype wire

### sv/erp_horner.sv
// ----------------------------------------------------------------------------
// erp_horner
// Quartic p(r) ~ e^-r by Horner's rule; each round is a multiply stage
// followed by a round-and-add stage.
// ----------------------------------------------------------------------------
`default_nettype none

module erp_horner #(
	parameter int F = 28
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire erp_pkg::erp_tag_t tag_in,
	input  wire logic [F-1:0]      r_in,
	output logic                   v_out,
	output erp_pkg::erp_tag_t      tag_out,
	output logic [F:0]             up_out
);
	import erp_pkg::*;

	localparam int TW = F + 3;
	localparam int MW = F + 2;
	localparam int PW = 2 * F + 2;
	localparam logic signed [TW-1:0] C1  = TW'(q40_to_f(C1_Q40, F));
	localparam logic signed [TW-1:0] C2  = TW'(q40_to_f(C2_Q40, F));
	localparam logic signed [TW-1:0] C3  = TW'(q40_to_f(C3_Q40, F));
	localparam logic signed [TW-1:0] C4  = TW'(q40_to_f(C4_Q40, F));
	localparam logic signed [TW-1:0] ONE = TW'(1) << F;
	localparam logic signed [TW-1:0] ADDC [0:3] = '{-C3, C2, -C1, ONE};
	localparam logic [PW:0] HALF = (PW + 1)'(1) << (F - 1);

	logic                 v_s    [0:8];
	erp_tag_t             tag_s  [0:8];
	logic [F-1:0]         r_s    [0:6];
	logic signed [TW-1:0] t_s    [0:4];
	logic [PW-1:0]        prod_s [0:3];
	logic                 neg_s  [0:3];
	logic signed [TW-1:0] p;

	assign v_s[0]   = v_in;
	assign tag_s[0] = tag_in;
	assign r_s[0]   = r_in;
	assign t_s[0]   = C4;

	for (genvar g = 0; g < 8; g++) begin : g_pass
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[g+1] <= tag_s[g];
			end
		end

		// r is last needed by the final multiply stage
		if (g < 6) begin : g_r
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[g+1] <= r_s[g];
				end
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_round
		logic [MW-1:0]        mag;
		logic [PW:0]          rnd;
		logic signed [TW-1:0] res;

		always_comb begin
			mag = t_s[g][TW-1] ? MW'(-t_s[g]) : MW'(t_s[g]);
			rnd = {1'b0, prod_s[g]} + HALF;
			res = TW'(rnd >> F);
			if (neg_s[g]) begin
				res = -res;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s[g] <= PW'(mag) * PW'(r_s[2*g]);
				neg_s[g]  <= t_s[g][TW-1];
				t_s[g+1]  <= res + ADDC[g];
			end
		end
	end

	// p cannot drop to zero for r in range; hold it at one if it ever does
	always_comb begin
		p      = t_s[4];
		up_out = (p <= 0) ? (F + 1)'(1) << F : p[F:0];
	end

	assign v_out   = v_s[8];
	assign tag_out = tag_s[8];

endmodule

`default_nettype wire

### sv/erp_recip.sv
// ----------------------------------------------------------------------------
// erp_recip
// Pipelined restoring divider: q = floor(2^(F+30) / p), 31 quotient bits,
// four bits per stage (three in the last), plus a sticky bit for a nonzero remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module erp_recip #(
	parameter int F = 28
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire erp_pkg::erp_tag_t tag_in,
	input  wire logic [F:0]        up_in,
	output logic                   v_out,
	output erp_pkg::erp_tag_t      tag_out,
	output logic [F:0]             up_out,
	output logic [30:0]            q_out,
	output logic                   sticky_out
);
	import erp_pkg::*;

	localparam int NST   = 8;
	localparam int PER   = 4;
	localparam int NSTEP = 31;

	logic        v_s   [0:NST];
	erp_tag_t    tag_s [0:NST];
	logic [F:0]  up_s  [0:NST];
	logic [F:0]  rem_s [0:NST];
	logic [30:0] q_s   [0:NST];

	assign v_s[0]   = v_in;
	assign tag_s[0] = tag_in;
	assign up_s[0]  = up_in;
	assign rem_s[0] = (F + 1)'(1) << F;
	assign q_s[0]   = '0;

	for (genvar g = 0; g < NST; g++) begin : g_stage
		logic [F:0]  rem_w, rs;
		logic [30:0] q_w;

		always_comb begin
			rem_w = rem_s[g];
			q_w   = q_s[g];
			rs    = rem_w;
			for (int j = 0; j < PER; j++) begin
				if (g * PER + j < NSTEP) begin
					rs = (g * PER + j == 0) ? rem_w : {rem_w[F-1:0], 1'b0};
					if (rs >= up_s[g]) begin
						rem_w = rs - up_s[g];
						q_w   = {q_w[29:0], 1'b1};
					end else begin
						rem_w = rs;
						q_w   = {q_w[29:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[g+1] <= tag_s[g];
				up_s[g+1]  <= up_s[g];
				rem_s[g+1] <= rem_w;
				q_s[g+1]   <= q_w;
			end
		end
	end

	assign v_out      = v_s[NST];
	assign tag_out    = tag_s[NST];
	assign up_out     = up_s[NST];
	assign q_out      = q_s[NST];
	assign sticky_out = rem_s[NST] != '0;

endmodule

`default_nettype wire

### sv/erp_pack.sv
// ----------------------------------------------------------------------------
// erp_pack
// Round to a 24-bit significand, place k in the exponent field, apply
// overflow, underflow and special cases; registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module erp_pack #(
	parameter int F = 28
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire erp_pkg::erp_tag_t tag_in,
	input  wire logic [F:0]        up_in,
	input  wire logic [30:0]       q_in,
	input  wire logic              sticky_in,
	output logic                   v_out,
	output logic [31:0]            y_out,
	output erp_pkg::erp_status_t   st_out,
	output logic                   last_out
);
	import erp_pkg::*;

	logic [F+23:0]      wx;
	logic [23:0]        mant0;
	logic               gd, rest;
	logic [24:0]        mant_r;
	logic signed [9:0]  kx, bexp, bexp_r;
	logic [22:0]        frac;
	logic [31:0]        y;
	erp_status_t        st;

	always_comb begin
		wx = {up_in[F-1:0], 24'b0};
		kx = $signed({2'b00, tag_in.k});
		if (tag_in.neg) begin
			if (up_in[F]) begin
				mant0 = 24'h800000;
				gd    = 1'b0;
				rest  = 1'b0;
				bexp  = 10'sd127 - kx;
			end else begin
				mant0 = wx[F+23:F];
				gd    = wx[F-1];
				rest  = |wx[F-2:0];
				bexp  = 10'sd126 - kx;
			end
		end else begin
			mant0 = q_in[30:7];
			gd    = q_in[6];
			rest  = (|q_in[5:0]) | sticky_in;
			bexp  = 10'sd127 + kx;
		end
		mant_r = {1'b0, mant0} + 25'(gd & (rest | mant0[0]));
		bexp_r = bexp + $signed({9'b0, mant_r[24]});
		frac   = mant_r[24] ? mant_r[23:1] : mant_r[22:0];
	end

	always_comb begin
		case (tag_in.spec)
			ST_NAN: begin
				y  = QNAN_BITS;
				st = ST_NAN;
			end
			ST_OVF: begin
				y  = PINF_BITS;
				st = ST_OVF;
			end
			ST_UNF: begin
				y  = '0;
				st = ST_UNF;
			end
			default: begin
				if (bexp < 10'sd1) begin
					y  = '0;
					st = ST_UNF;
				end else if (bexp_r >= 10'sd255) begin
					y  = PINF_BITS;
					st = ST_OVF;
				end else begin
					y  = {1'b0, bexp_r[7:0], frac};
					st = ST_OK;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_out    <= y;
			st_out   <= st;
			last_out <= tag_in.last;
		end
	end

endmodule

`default_nettype wire

### sv/exp_range_reduced_polynomial.sv
// ----------------------------------------------------------------------------
// exp_range_reduced_polynomial
// e^x for IEEE single precision via range reduction and a quartic.
//
//   channel  valid      stall      payload
//   in       in_valid   in_stall   x_bits, in_last
//   out      out_valid  out_stall  y_bits, status, out_last
//
// One item enters every cycle while the pipe is not held; the stages in order
// are decode and shift, ln2 reduction, Horner evaluation, reciprocal divider, pack.
// The pipe advances as a whole; it holds while a result sits in the output
// register with out_stall high, and in_stall follows that hold.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module exp_range_reduced_polynomial #(
	parameter int FRAC_BITS = 28
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] x_bits,
	input  wire logic        in_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      y_bits,
	output logic [1:0]       status,
	output logic             out_last
);
	import erp_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int AXW = F + 7;

	logic             adv;
	logic [7:0]       ex, ex_eff, sh;
	logic [23:0]      m;
	logic [23+F:0]    mf;
	erp_tag_t         tag_d;
	logic             v_s1;
	erp_tag_t         tag_s1;
	logic [AXW-1:0]   ax_s1;
	logic             v_k, v_h, v_d;
	erp_tag_t         tag_k, tag_h, tag_d2;
	logic [F-1:0]     r_k;
	logic [F:0]       up_h, up_d;
	logic [30:0]      q_d;
	logic             sticky_d;
	erp_status_t      st_o;

	assign adv      = ~(out_valid & out_stall);
	assign in_stall = ~adv;

	always_comb begin
		ex          = x_bits[30:23];
		ex_eff      = (ex == 8'd0) ? 8'd1 : ex;
		m           = {(ex != 8'd0), x_bits[22:0]};
		sh          = 8'd150 - ex_eff;
		mf          = {m, {F{1'b0}}};
		tag_d.neg   = x_bits[31];
		tag_d.last  = in_last;
		tag_d.k     = '0;
		if (ex == 8'd255 && x_bits[22:0] != '0) begin
			tag_d.spec = ST_NAN;
		end else if (ex >= 8'd134) begin
			tag_d.spec = x_bits[31] ? ST_UNF : ST_OVF;
		end else begin
			tag_d.spec = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_d;
			ax_s1  <= AXW'(mf >> sh);
		end
	end

	erp_kdiv #(.F(F)) u_kdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.v_in    (v_s1),
		.tag_in  (tag_s1),
		.ax_in   (ax_s1),
		.v_out   (v_k),
		.tag_out (tag_k),
		.r_out   (r_k)
	);

	erp_horner #(.F(F)) u_horner (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.v_in    (v_k),
		.tag_in  (tag_k),
		.r_in    (r_k),
		.v_out   (v_h),
		.tag_out (tag_h),
		.up_out  (up_h)
	);

	erp_recip #(.F(F)) u_recip (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.v_in       (v_h),
		.tag_in     (tag_h),
		.up_in      (up_h),
		.v_out      (v_d),
		.tag_out    (tag_d2),
		.up_out     (up_d),
		.q_out      (q_d),
		.sticky_out (sticky_d)
	);

	erp_pack #(.F(F)) u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.v_in      (v_d),
		.tag_in    (tag_d2),
		.up_in     (up_d),
		.q_in      (q_d),
		.sticky_in (sticky_d),
		.v_out     (out_valid),
		.y_out     (y_bits),
		.st_out    (st_o),
		.last_out  (out_last)
	);

	assign status = st_o;

	a_nan_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NAN |-> y_bits == QNAN_BITS)
		else $error("NaN status without quiet NaN result");

	a_ovf_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OVF |-> y_bits == PINF_BITS)
		else $error("overflow status without +inf result");

	a_unf_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNF |-> y_bits == 32'd0)
		else $error("underflow status without zero result");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |->
		!y_bits[31] && y_bits[30:23] != 8'd0 && y_bits[30:23] != 8'hFF)
		else $error("normal status with non-normal result");

endmodule

`default_nettype wire
